### hw/rtl/dmxt_pkg.sv
// ----------------------------------------------------------------------------
// dmxt_pkg
// Shared types and constants of the DMX512 transceiver: payload structs,
// command codes, register indexes and timing limits.
// ----------------------------------------------------------------------------
package dmxt_pkg;

  localparam int SLOTS      = 512;
  localparam int MIN_SLOTS  = 24;
  localparam int TIMER_BITS = 20;

  localparam int STORE_AW = $clog2(SLOTS);
  localparam int SLOT_W   = $clog2(SLOTS + 1);
  localparam int REG_W    = 20;
  localparam int IDX_W    = 2;

  localparam logic [REG_W-1:0] REG_MAX     = REG_W'(1000000);
  localparam logic [REG_W-1:0] BREAK_MIN   = REG_W'(88);
  localparam logic [REG_W-1:0] MAB_MIN     = REG_W'(8);
  localparam logic [REG_W-1:0] BREAK_RESET = REG_W'(176);
  localparam logic [REG_W-1:0] MAB_RESET   = REG_W'(16);
  localparam logic [REG_W-1:0] MBF_RESET   = REG_W'(100);

  // Register indexes on the configuration port.
  localparam logic [IDX_W-1:0] REG_BREAK = 2'd0;
  localparam logic [IDX_W-1:0] REG_MAB   = 2'd1;
  localparam logic [IDX_W-1:0] REG_MBF   = 2'd2;

  // Command codes of an input item.
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_RX    = 3'd1;
  localparam logic [2:0] CMD_UART  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;
  localparam logic [2:0] CMD_START = 3'd5;
  localparam logic [2:0] CMD_STOP  = 3'd6;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] rx_byte;
    logic       rx_break;
    logic [8:0] channel_addr;
    logic [7:0] write_data;
  } dmxt_in_t;

  typedef struct packed {
    logic       line_break;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [7:0] read_data;
    logic       frame_received;
    logic       frame_sent;
    logic       rx_error;
  } dmxt_out_t;

endpackage

### hw/rtl/dmx512_transceiver.sv
// ----------------------------------------------------------------------------
// dmx512_transceiver
// DMX512 frame engine: transmit framing (mark, break, mark after break,
// start code and slot data) and receive framing with slot capture.
// ----------------------------------------------------------------------------
//  channel | ports                          | transfer
//  --------+--------------------------------+--------------------------------
//  input   | in_valid, in_ready, in_data    | one command item per handshake
//  result  | out_valid, out_ready, out_data | one result item per input item
//  config  | cfg_we, cfg_index, cfg_data    | write on cfg_we, no wait
//
// One item is accepted per cycle while in_ready is high; its result goes
// through the read stage (the registered read of the channel stores) and
// the result register. After reset a clearing pass zeroes all 512 entries
// of both stores with in_ready held low; config writes are taken throughout.
// A stalled result holds the pipeline: in_ready drops only when both the
// result register and the read stage are full.
// ----------------------------------------------------------------------------
module dmx512_transceiver
  import dmxt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  dmxt_in_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output dmxt_out_t        out_data,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    TX_STOP  = 3'd0,
    TX_MBF   = 3'd1,
    TX_BREAK = 3'd2,
    TX_MAB   = 3'd3,
    TX_DATA  = 3'd4
  } tx_mode_t;

  typedef enum logic [1:0] {
    RX_WAIT  = 2'd0,
    RX_ARMED = 2'd1,
    RX_DATA  = 2'd2,
    RX_ERROR = 2'd3
  } rx_mode_t;

  typedef struct packed {
    dmxt_out_t res;
    logic      tx_sel;
    logic      rd_sel;
  } stage_t;

  logic [REG_W-1:0] break_r, mab_r, mbf_r;

  tx_mode_t              tx_mode_r, tx_mode_nxt;
  logic [SLOT_W-1:0]     tx_slot_r, tx_slot_nxt;
  logic [TIMER_BITS-1:0] tx_timer_r, tx_timer_nxt;
  rx_mode_t              rx_mode_r, rx_mode_nxt;
  logic [SLOT_W-1:0]     rx_slot_r, rx_slot_nxt;

  logic                clr_active_r;
  logic [STORE_AW-1:0] clr_addr_r;

  logic      p1_valid_r;
  stage_t    p1_r, p1_nxt;
  logic      out_valid_r;
  dmxt_out_t out_r, out_nxt;

  logic                  in_acc, p1_adv;
  logic [TIMER_BITS-1:0] tim_inc, tim_lim;
  logic [SLOT_W-1:0]     rx_slot_inc;

  logic                tx_we, tx_re, rx_we, rx_re;
  logic [STORE_AW-1:0] tx_waddr, rx_waddr;
  logic [7:0]          tx_wdata, rx_wdata, tx_rdata, rx_rdata;

  assign p1_adv   = !out_valid_r || out_ready;
  assign in_ready = !clr_active_r && (!p1_valid_r || p1_adv);
  assign in_acc   = in_valid && in_ready;

  assign tim_inc     = tx_timer_r + TIMER_BITS'(1);
  assign rx_slot_inc = rx_slot_r + SLOT_W'(1);

  always_comb begin
    case (tx_mode_r)
      TX_MBF:   tim_lim = TIMER_BITS'(mbf_r);
      TX_BREAK: tim_lim = TIMER_BITS'(break_r);
      default:  tim_lim = TIMER_BITS'(mab_r);
    endcase
  end

  always_comb begin
    tx_mode_nxt  = tx_mode_r;
    tx_slot_nxt  = tx_slot_r;
    tx_timer_nxt = tx_timer_r;
    rx_mode_nxt  = rx_mode_r;
    rx_slot_nxt  = rx_slot_r;
    p1_nxt       = '0;
    tx_re        = 1'b0;
    rx_re        = 1'b0;
    rx_we        = 1'b0;
    tx_we        = 1'b0;

    if (in_acc) begin
      case (in_data.cmd)
        CMD_TICK: begin
          if (tx_mode_r == TX_MBF || tx_mode_r == TX_BREAK || tx_mode_r == TX_MAB) begin
            tx_timer_nxt = tim_inc;
            if (tim_inc >= tim_lim) begin
              tx_timer_nxt = '0;
              case (tx_mode_r)
                TX_MBF:   tx_mode_nxt = TX_BREAK;
                TX_BREAK: tx_mode_nxt = TX_MAB;
                default: begin
                  // End of mark after break: the start code goes out now.
                  tx_mode_nxt           = TX_DATA;
                  tx_slot_nxt           = '0;
                  p1_nxt.res.tx_valid = 1'b1;
                end
              endcase
            end
          end
        end
        CMD_RX: begin
          if (in_data.rx_break) begin
            if (rx_mode_r == RX_DATA && rx_slot_r >= SLOT_W'(MIN_SLOTS)) begin
              p1_nxt.res.frame_received = 1'b1;
            end
            rx_mode_nxt = (in_data.rx_byte == 8'd0) ? RX_ARMED : RX_ERROR;
          end else if (rx_mode_r == RX_ARMED) begin
            if (in_data.rx_byte == 8'd0) begin
              rx_slot_nxt = '0;
              rx_mode_nxt = RX_DATA;
            end else begin
              rx_mode_nxt = RX_ERROR;
            end
          end else if (rx_mode_r == RX_DATA) begin
            rx_we       = 1'b1;
            rx_slot_nxt = rx_slot_inc;
            if (rx_slot_inc >= SLOT_W'(SLOTS)) begin
              p1_nxt.res.frame_received = 1'b1;
              rx_mode_nxt               = RX_WAIT;
            end
          end
        end
        CMD_UART: begin
          if (tx_mode_r == TX_DATA) begin
            if (tx_slot_r < SLOT_W'(SLOTS)) begin
              tx_re               = 1'b1;
              p1_nxt.tx_sel       = 1'b1;
              p1_nxt.res.tx_valid = 1'b1;
              tx_slot_nxt         = tx_slot_r + SLOT_W'(1);
            end else begin
              tx_mode_nxt           = TX_MBF;
              tx_timer_nxt          = '0;
              p1_nxt.res.frame_sent = 1'b1;
            end
          end
        end
        CMD_WRITE: tx_we = 1'b1;
        CMD_READ: begin
          rx_re         = 1'b1;
          p1_nxt.rd_sel = 1'b1;
        end
        CMD_START: begin
          if (!(tx_mode_r == TX_MBF || tx_mode_r == TX_BREAK ||
                tx_mode_r == TX_MAB || tx_mode_r == TX_DATA)) begin
            tx_mode_nxt  = TX_MBF;
            tx_timer_nxt = '0;
          end
        end
        CMD_STOP: begin
          tx_mode_nxt  = TX_STOP;
          tx_timer_nxt = '0;
        end
        default: ;
      endcase
    end

    p1_nxt.res.line_break = (tx_mode_nxt == TX_BREAK);
    p1_nxt.res.rx_error   = (rx_mode_nxt == RX_ERROR);
  end

  // Store write ports; the clearing pass owns them until it finishes.
  always_comb begin
    if (clr_active_r) begin
      tx_waddr = clr_addr_r;
      tx_wdata = 8'd0;
      rx_waddr = clr_addr_r;
      rx_wdata = 8'd0;
    end else begin
      tx_waddr = in_data.channel_addr;
      tx_wdata = in_data.write_data;
      rx_waddr = rx_slot_r[STORE_AW-1:0];
      rx_wdata = in_data.rx_byte;
    end
  end

  dmxt_ram #(.WIDTH(8), .DEPTH(SLOTS)) u_tx_store (
    .clk   (clk),
    .we    (tx_we || clr_active_r),
    .waddr (tx_waddr),
    .wdata (tx_wdata),
    .re    (tx_re),
    .raddr (tx_slot_r[STORE_AW-1:0]),
    .rdata (tx_rdata)
  );

  dmxt_ram #(.WIDTH(8), .DEPTH(SLOTS)) u_rx_store (
    .clk   (clk),
    .we    (rx_we || clr_active_r),
    .waddr (rx_waddr),
    .wdata (rx_wdata),
    .re    (rx_re),
    .raddr (in_data.channel_addr),
    .rdata (rx_rdata)
  );

  always_comb begin
    out_nxt           = p1_r.res;
    out_nxt.tx_byte   = p1_r.tx_sel ? tx_rdata : 8'd0;
    out_nxt.read_data = p1_r.rd_sel ? rx_rdata : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      break_r      <= BREAK_RESET;
      mab_r        <= MAB_RESET;
      mbf_r        <= MBF_RESET;
      tx_mode_r    <= TX_STOP;
      tx_slot_r    <= '0;
      tx_timer_r   <= '0;
      rx_mode_r    <= RX_WAIT;
      rx_slot_r    <= '0;
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      p1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BREAK: if (cfg_data >= BREAK_MIN && cfg_data <= REG_MAX) break_r <= cfg_data;
          REG_MAB:   if (cfg_data >= MAB_MIN && cfg_data <= REG_MAX) mab_r <= cfg_data;
          REG_MBF:   if (cfg_data <= REG_MAX) mbf_r <= cfg_data;
          default: ;
        endcase
      end
      tx_mode_r  <= tx_mode_nxt;
      tx_slot_r  <= tx_slot_nxt;
      tx_timer_r <= tx_timer_nxt;
      rx_mode_r  <= rx_mode_nxt;
      rx_slot_r  <= rx_slot_nxt;
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + STORE_AW'(1);
        if (clr_addr_r == STORE_AW'(SLOTS - 1)) begin
          clr_active_r <= 1'b0;
        end
      end
      if (in_ready) begin
        p1_valid_r <= in_valid;
        p1_r       <= p1_nxt;
      end
      if (p1_adv) begin
        out_valid_r <= p1_valid_r;
        out_r       <= out_nxt;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### hw/rtl/dmxt_ram.sv
// ----------------------------------------------------------------------------
// dmxt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dmxt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/dmxt_checker.sv
// ----------------------------------------------------------------------------
// dmxt_checker
// Port-level checks of the DMX512 transceiver, bound to the top level.
// ----------------------------------------------------------------------------
module dmxt_checker
  import dmxt_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input dmxt_in_t         in_data,
  input logic             out_valid,
  input logic             out_ready,
  input dmxt_out_t        out_data,
  input logic             cfg_we,
  input logic [IDX_W-1:0] cfg_index,
  input logic [REG_W-1:0] cfg_data
);

  // A stalled result item keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // No byte value is shown without a byte handed to the UART.
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.tx_valid |-> out_data.tx_byte == 8'd0)
    else $error("tx_byte set without tx_valid");

  // A byte is only sent in data mode, so never during break or at frame end.
  a_tx_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.tx_valid |-> !out_data.line_break && !out_data.frame_sent)
    else $error("tx_valid outside data mode");

  // The frame-sent item leaves the transmitter in mark, not in break.
  a_sent_mark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_sent |-> !out_data.line_break)
    else $error("frame_sent while line held in break");

endmodule

bind dmx512_transceiver dmxt_checker u_dmxt_checker (.*);
